### rtl/core/bfr_pkg.sv
`default_nettype none
package bfr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 16;
  localparam int unsigned EventW = 3;
  localparam int unsigned PhaseW = 4;
  localparam int unsigned CfgIdxW = 3;

  // event codes
  localparam logic [EventW-1:0] EV_NONE    = 3'd0;
  localparam logic [EventW-1:0] EV_START   = 3'd1;
  localparam logic [EventW-1:0] EV_PAYLOAD = 3'd2;
  localparam logic [EventW-1:0] EV_FRAME   = 3'd3;
  localparam logic [EventW-1:0] EV_GOOD    = 3'd4;
  localparam logic [EventW-1:0] EV_LENERR  = 3'd5;
  localparam logic [EventW-1:0] EV_ENDERR  = 3'd6;
  localparam logic [EventW-1:0] EV_SUMERR  = 3'd7;

  // parser phases
  localparam logic [PhaseW-1:0] PH_CLEAR   = 4'd0;
  localparam logic [PhaseW-1:0] PH_HUNT    = 4'd1;
  localparam logic [PhaseW-1:0] PH_LEN_HI  = 4'd2;
  localparam logic [PhaseW-1:0] PH_LEN_LO  = 4'd3;
  localparam logic [PhaseW-1:0] PH_PAYLOAD = 4'd4;
  localparam logic [PhaseW-1:0] PH_SUM_HI  = 4'd5;
  localparam logic [PhaseW-1:0] PH_SUM_LO  = 4'd6;
  localparam logic [PhaseW-1:0] PH_END1    = 4'd7;
  localparam logic [PhaseW-1:0] PH_END2    = 4'd8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_START_FIRST  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_START_SECOND = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_END_FIRST    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_END_SECOND   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MAX_PAYLOAD  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SUM_MASK     = 3'd5;

  // register reset values
  localparam logic [ByteW-1:0] RST_START_FIRST  = 8'hA0;
  localparam logic [ByteW-1:0] RST_START_SECOND = 8'hA2;
  localparam logic [ByteW-1:0] RST_END_FIRST    = 8'hB0;
  localparam logic [ByteW-1:0] RST_END_SECOND   = 8'hB3;
  localparam logic [WordW-1:0] RST_MAX_PAYLOAD  = 16'd120;
  localparam logic [WordW-1:0] RST_SUM_MASK     = 16'hFFFF;

  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
  } in_req_t;

  typedef struct packed {
    logic [EventW-1:0] event_res;
    logic [ByteW-1:0]  payload_byte;
    logic [WordW-1:0]  payload_index;
    logic [WordW-1:0]  frame_length;
    logic [WordW-1:0]  computed_sum;
    logic [WordW-1:0]  received_sum;
  } out_req_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [WordW-1:0]   value;
  } cfg_req_t;

endpackage
`default_nettype wire

### rtl/core/bfr_stream_if.sv
`default_nettype none
interface bfr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/binary_frame_receiver_top.sv
`default_nettype none
// Channel  | Dir | Payload                                        | Role
// ---------+-----+------------------------------------------------+-----------------------
// in_ch    | in  | rx_byte                                        | one received byte
// out_ch   | out | event_res, payload_byte, payload_index,        | one result per byte
//          |     | frame_length, computed_sum, received_sum       |
// cfg_ch   | in  | index, value                                   | register write
//
// One byte per cycle while out_ch is ready: the byte is caught in an input
// register, the phase update and 16-bit add run in one combinational pass,
// and the result lands in the output register. Reset (rst_n low,
// synchronous) empties both stages and restores the phase, counters and
// configuration defaults. A stall on out_ch holds the result; the input
// register still takes a request while it is empty, or while the output stage
// is free or being drained in the same cycle. cfg_ch is always ready.
module binary_frame_receiver_top (
  input  wire            clk,
  input  wire            rst_n,
  bfr_stream_if.sink     in_ch,
  bfr_stream_if.source   out_ch,
  bfr_stream_if.sink     cfg_ch
);

  // ---------------- configuration registers ----------------
  logic [bfr_pkg::ByteW-1:0] start_first_r, start_second_r, end_first_r, end_second_r;
  logic [bfr_pkg::WordW-1:0] max_payload_r, sum_mask_r;
  bfr_pkg::cfg_req_t         cfg_req;
  logic                      cfg_wr;

  assign cfg_ch.ready = 1'b1;
  assign cfg_req      = cfg_ch.data;
  assign cfg_wr       = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_first_r  <= bfr_pkg::RST_START_FIRST;
      start_second_r <= bfr_pkg::RST_START_SECOND;
      end_first_r    <= bfr_pkg::RST_END_FIRST;
      end_second_r   <= bfr_pkg::RST_END_SECOND;
      max_payload_r  <= bfr_pkg::RST_MAX_PAYLOAD;
      sum_mask_r     <= bfr_pkg::RST_SUM_MASK;
    end else if (cfg_wr) begin
      unique case (cfg_req.index)
        bfr_pkg::REG_START_FIRST:  start_first_r  <= cfg_req.value[bfr_pkg::ByteW-1:0];
        bfr_pkg::REG_START_SECOND: start_second_r <= cfg_req.value[bfr_pkg::ByteW-1:0];
        bfr_pkg::REG_END_FIRST:    end_first_r    <= cfg_req.value[bfr_pkg::ByteW-1:0];
        bfr_pkg::REG_END_SECOND:   end_second_r   <= cfg_req.value[bfr_pkg::ByteW-1:0];
        bfr_pkg::REG_MAX_PAYLOAD:  max_payload_r  <= cfg_req.value;
        bfr_pkg::REG_SUM_MASK:     sum_mask_r     <= cfg_req.value;
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // ---------------- input stage ----------------
  logic                      in_valid_r;
  logic [bfr_pkg::ByteW-1:0] in_byte_r;
  logic                      out_valid_r;
  bfr_pkg::out_req_t         out_data_r;
  logic                      advance;   // input stage moves into the output stage
  bfr_pkg::in_req_t          in_req;

  assign in_req       = in_ch.data;
  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_req.rx_byte;
    end
  end

  // ---------------- parser state ----------------
  logic [bfr_pkg::PhaseW-1:0] phase_r, phase_nxt, phase_eff;
  logic [bfr_pkg::ByteW-1:0]  prev_byte_r;
  logic [bfr_pkg::WordW-1:0]  decl_len_r, decl_len_nxt;
  logic [bfr_pkg::WordW-1:0]  count_r, count_nxt;
  logic [bfr_pkg::WordW-1:0]  run_sum_r, run_sum_nxt;
  logic [bfr_pkg::WordW-1:0]  car_sum_r, car_sum_nxt;
  logic                       idle_clear, start_pair, len_bad;
  logic [bfr_pkg::WordW-1:0]  len_full, count_inc;
  logic [bfr_pkg::WordW-1:0]  base_len, base_cnt, base_run, base_car;
  bfr_pkg::out_req_t          out_nxt;

  always_comb begin
    // phase 0 and the unused codes clear the frame before the byte is looked at
    idle_clear = (phase_r == bfr_pkg::PH_CLEAR) || (phase_r > bfr_pkg::PH_END2);
    phase_eff  = idle_clear ? bfr_pkg::PH_HUNT : phase_r;
    base_len   = idle_clear ? '0 : decl_len_r;
    base_cnt   = idle_clear ? '0 : count_r;
    base_run   = idle_clear ? '0 : run_sum_r;
    base_car   = idle_clear ? '0 : car_sum_r;

    start_pair = (in_byte_r == start_second_r) && (prev_byte_r == start_first_r);
    len_full   = {base_len[bfr_pkg::WordW-1:bfr_pkg::ByteW], in_byte_r};
    len_bad    = (len_full == '0) || (len_full > max_payload_r);
    count_inc  = base_cnt + 16'd1;

    phase_nxt    = phase_eff;
    decl_len_nxt = base_len;
    count_nxt    = base_cnt;
    run_sum_nxt  = base_run;
    car_sum_nxt  = base_car;
    out_nxt                = '0;
    out_nxt.event_res      = bfr_pkg::EV_NONE;

    if (start_pair) begin
      // resync from any phase
      phase_nxt         = bfr_pkg::PH_LEN_HI;
      decl_len_nxt      = '0;
      count_nxt         = '0;
      run_sum_nxt       = '0;
      car_sum_nxt       = '0;
      out_nxt.event_res = bfr_pkg::EV_START;
    end else begin
      unique case (phase_eff)
        bfr_pkg::PH_LEN_HI: begin
          decl_len_nxt      = {in_byte_r, 8'h00};
          phase_nxt         = bfr_pkg::PH_LEN_LO;
          out_nxt.event_res = bfr_pkg::EV_FRAME;
        end
        bfr_pkg::PH_LEN_LO: begin
          decl_len_nxt = len_full;
          if (len_bad) begin
            phase_nxt         = bfr_pkg::PH_CLEAR;
            out_nxt.event_res = bfr_pkg::EV_LENERR;
          end else begin
            phase_nxt         = bfr_pkg::PH_PAYLOAD;
            out_nxt.event_res = bfr_pkg::EV_FRAME;
          end
        end
        bfr_pkg::PH_PAYLOAD: begin
          if (base_cnt < base_len) begin
            out_nxt.payload_byte  = in_byte_r;
            out_nxt.payload_index = base_cnt;
            run_sum_nxt           = base_run + {8'h00, in_byte_r};
            count_nxt             = count_inc;
            if (count_inc == base_len) begin
              phase_nxt = bfr_pkg::PH_SUM_HI;
            end
            out_nxt.event_res = bfr_pkg::EV_PAYLOAD;
          end else begin
            // overrun guard, not reached by normal transitions
            phase_nxt         = bfr_pkg::PH_CLEAR;
            out_nxt.event_res = bfr_pkg::EV_LENERR;
          end
        end
        bfr_pkg::PH_SUM_HI: begin
          car_sum_nxt       = {in_byte_r, 8'h00};
          phase_nxt         = bfr_pkg::PH_SUM_LO;
          out_nxt.event_res = bfr_pkg::EV_FRAME;
        end
        bfr_pkg::PH_SUM_LO: begin
          car_sum_nxt       = {base_car[bfr_pkg::WordW-1:bfr_pkg::ByteW], in_byte_r};
          phase_nxt         = bfr_pkg::PH_END1;
          out_nxt.event_res = bfr_pkg::EV_FRAME;
        end
        bfr_pkg::PH_END1: begin
          if (in_byte_r == end_first_r) begin
            phase_nxt         = bfr_pkg::PH_END2;
            out_nxt.event_res = bfr_pkg::EV_FRAME;
          end else begin
            phase_nxt         = bfr_pkg::PH_CLEAR;
            out_nxt.event_res = bfr_pkg::EV_ENDERR;
          end
        end
        bfr_pkg::PH_END2: begin
          phase_nxt = bfr_pkg::PH_CLEAR;
          if (in_byte_r != end_second_r) begin
            out_nxt.event_res = bfr_pkg::EV_ENDERR;
          end else if ((base_run & sum_mask_r) == base_car) begin
            out_nxt.event_res = bfr_pkg::EV_GOOD;
          end else begin
            out_nxt.event_res = bfr_pkg::EV_SUMERR;
          end
        end
        default: begin
          // hunting: nothing to report
          out_nxt.event_res = bfr_pkg::EV_NONE;
        end
      endcase
    end

    out_nxt.frame_length = decl_len_nxt;
    out_nxt.computed_sum = run_sum_nxt & sum_mask_r;
    out_nxt.received_sum = car_sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= bfr_pkg::PH_CLEAR;
      prev_byte_r <= '0;
      decl_len_r  <= '0;
      count_r     <= '0;
      run_sum_r   <= '0;
      car_sum_r   <= '0;
    end else if (advance) begin
      phase_r     <= phase_nxt;
      prev_byte_r <= in_byte_r;
      decl_len_r  <= decl_len_nxt;
      count_r     <= count_nxt;
      run_sum_r   <= run_sum_nxt;
      car_sum_r   <= car_sum_nxt;
    end
  end

  // ---------------- output stage ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // ---------------- checks ----------------
  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= bfr_pkg::PH_END2)
    else $error("parser phase left the legal range");

  a_payload_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.event_res == bfr_pkg::EV_PAYLOAD |->
      out_data_r.payload_index < out_data_r.frame_length)
    else $error("payload index not below declared length");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.event_res == bfr_pkg::EV_START |->
      out_data_r.frame_length == '0 && out_data_r.computed_sum == '0 &&
      out_data_r.received_sum == '0)
    else $error("resync left frame state behind");

  a_nonpayload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.event_res != bfr_pkg::EV_PAYLOAD |->
      out_data_r.payload_byte == '0 && out_data_r.payload_index == '0)
    else $error("payload fields set outside a payload byte");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == bfr_pkg::PH_PAYLOAD |-> count_r < decl_len_r)
    else $error("byte count reached length while still in payload");

endmodule
`default_nettype wire

### dv/tb_binary_frame_receiver_top.sv
`timescale 1ns / 1ps

module tb_binary_frame_receiver_top;

  logic clk;
  logic rst_n;

  bfr_stream_if #(.payload_t(bfr_pkg::in_req_t))  in_ch ();
  bfr_stream_if #(.payload_t(bfr_pkg::out_req_t)) out_ch ();
  bfr_stream_if #(.payload_t(bfr_pkg::cfg_req_t)) cfg_ch ();

  binary_frame_receiver_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Register shadows, kept in step with every accepted config write.
  logic [7:0]  mark_start_first;
  logic [7:0]  mark_start_second;
  logic [7:0]  mark_end_first;
  logic [7:0]  mark_end_second;
  logic [15:0] payload_limit;
  logic [15:0] sum_limit_mask;

  // Deframer state as the block should hold it.
  logic [3:0]  ph;
  logic [7:0]  last_byte;
  logic [15:0] frame_len;
  logic [15:0] payload_count;
  logic [15:0] byte_sum;
  logic [15:0] carried_sum;

  bfr_pkg::out_req_t pending_results[$];
  int unsigned bytes_sent;
  int unsigned mismatches;

  // Traffic shaping knobs. idle_enabled gates the random gaps on both sides;
  // hold_off_req asks the hold-off process for one long output stall.
  bit          idle_enabled;
  bit          hold_off_req;
  logic        sink_hold;

  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned IdlePct       = 34;
  localparam int unsigned DrainLimit    = 50000;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake hangs.
  initial begin
    #2ms;
    $display("binary_frame_receiver_top regression: fail");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------------
  function automatic void clear_frame_state();
    frame_len     = '0;
    payload_count = '0;
    byte_sum      = '0;
    carried_sum   = '0;
  endfunction

  function automatic void reset_deframer();
    mark_start_first  = bfr_pkg::RST_START_FIRST;
    mark_start_second = bfr_pkg::RST_START_SECOND;
    mark_end_first    = bfr_pkg::RST_END_FIRST;
    mark_end_second   = bfr_pkg::RST_END_SECOND;
    payload_limit     = bfr_pkg::RST_MAX_PAYLOAD;
    sum_limit_mask    = bfr_pkg::RST_SUM_MASK;
    ph                = bfr_pkg::PH_CLEAR;
    last_byte         = '0;
    clear_frame_state();
  endfunction

  // Advances the shadow deframer by one byte and returns the result it owes.
  function automatic bfr_pkg::out_req_t deframe_byte(input logic [7:0] b);
    bfr_pkg::out_req_t r;
    logic [7:0]        prev;
    prev      = last_byte;
    last_byte = b;
    r         = '0;
    r.event_res = bfr_pkg::EV_NONE;

    // Phase 0 (and any stray code) clears before the byte is looked at, so
    // the byte right after a frame event can already close a start pair.
    if (ph == bfr_pkg::PH_CLEAR || ph > bfr_pkg::PH_END2) begin
      clear_frame_state();
      ph = bfr_pkg::PH_HUNT;
    end

    // A start pair resyncs from any phase, mid-payload included.
    if (b == mark_start_second && prev == mark_start_first) begin
      clear_frame_state();
      ph          = bfr_pkg::PH_LEN_HI;
      r.event_res = bfr_pkg::EV_START;
    end else begin
      unique case (ph)
        bfr_pkg::PH_LEN_HI: begin
          frame_len   = {b, 8'h00};
          ph          = bfr_pkg::PH_LEN_LO;
          r.event_res = bfr_pkg::EV_FRAME;
        end
        bfr_pkg::PH_LEN_LO: begin
          frame_len = {frame_len[15:8], b};
          if (frame_len == 16'd0 || frame_len > payload_limit) begin
            ph          = bfr_pkg::PH_CLEAR;
            r.event_res = bfr_pkg::EV_LENERR;
          end else begin
            ph          = bfr_pkg::PH_PAYLOAD;
            r.event_res = bfr_pkg::EV_FRAME;
          end
        end
        bfr_pkg::PH_PAYLOAD: begin
          if (payload_count < frame_len) begin
            r.payload_byte  = b;
            r.payload_index = payload_count;
            byte_sum        = byte_sum + {8'h00, b};
            payload_count   = payload_count + 16'd1;
            if (payload_count == frame_len) ph = bfr_pkg::PH_SUM_HI;
            r.event_res = bfr_pkg::EV_PAYLOAD;
          end else begin
            ph          = bfr_pkg::PH_CLEAR;
            r.event_res = bfr_pkg::EV_LENERR;
          end
        end
        bfr_pkg::PH_SUM_HI: begin
          carried_sum = {b, 8'h00};
          ph          = bfr_pkg::PH_SUM_LO;
          r.event_res = bfr_pkg::EV_FRAME;
        end
        bfr_pkg::PH_SUM_LO: begin
          carried_sum = {carried_sum[15:8], b};
          ph          = bfr_pkg::PH_END1;
          r.event_res = bfr_pkg::EV_FRAME;
        end
        bfr_pkg::PH_END1: begin
          if (b == mark_end_first) begin
            ph          = bfr_pkg::PH_END2;
            r.event_res = bfr_pkg::EV_FRAME;
          end else begin
            ph          = bfr_pkg::PH_CLEAR;
            r.event_res = bfr_pkg::EV_ENDERR;
          end
        end
        bfr_pkg::PH_END2: begin
          if (b != mark_end_second) begin
            r.event_res = bfr_pkg::EV_ENDERR;
          end else if ((byte_sum & sum_limit_mask) == carried_sum) begin
            r.event_res = bfr_pkg::EV_GOOD;
          end else begin
            r.event_res = bfr_pkg::EV_SUMERR;
          end
          ph = bfr_pkg::PH_CLEAR;
        end
        default: r.event_res = bfr_pkg::EV_NONE;  // hunting, no start pair yet
      endcase
    end

    r.frame_length = frame_len;
    r.computed_sum = byte_sum & sum_limit_mask;
    r.received_sum = carried_sum;
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // Result checking and output-side flow control
  // ------------------------------------------------------------------------
  task automatic check_result(input bfr_pkg::out_req_t got);
    bfr_pkg::out_req_t exp;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result with nothing pending: ev=%0d byte=%02h idx=%0d len=%0d",
                 $time, got.event_res, got.payload_byte, got.payload_index,
                 got.frame_length);
      return;
    end
    exp = pending_results.pop_front();
    if (got.event_res     !== exp.event_res     ||
        got.payload_byte  !== exp.payload_byte  ||
        got.payload_index !== exp.payload_index ||
        got.frame_length  !== exp.frame_length  ||
        got.computed_sum  !== exp.computed_sum  ||
        got.received_sum  !== exp.received_sum) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: mismatch exp ev=%0d byte=%02h idx=%0d len=%0d csum=%04h rsum=%04h",
                 $time, exp.event_res, exp.payload_byte, exp.payload_index,
                 exp.frame_length, exp.computed_sum, exp.received_sum);
        $display("%0t:          got ev=%0d byte=%02h idx=%0d len=%0d csum=%04h rsum=%04h",
                 $time, got.event_res, got.payload_byte, got.payload_index,
                 got.frame_length, got.computed_sum, got.received_sum);
      end
    end
  endtask

  // Signals are read right after the edge, so they hold their pre-edge values.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) check_result(out_ch.data);
      if (sink_hold)                                          out_ch.ready <= 1'b0;
      else if (idle_enabled && $urandom_range(99) < IdlePct)  out_ch.ready <= 1'b0;
      else                                                    out_ch.ready <= 1'b1;
    end
  end

  // One long output stall on request, counted here so the sender keeps
  // offering bytes until the block backs up and drops in_ch.ready.
  initial begin
    sink_hold <= 1'b0;
    forever begin
      wait (hold_off_req);
      sink_hold <= 1'b1;
      repeat (HoldOffCycles) @(posedge clk);
      sink_hold   <= 1'b0;
      hold_off_req = 1'b0;
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------
  // Offers one byte; the expectation is queued once the request is taken.
  task automatic send_byte(input logic [7:0] b);
    bfr_pkg::out_req_t exp_res;
    if (idle_enabled) begin
      while ($urandom_range(99) < IdlePct) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid        <= 1'b1;
    in_ch.data.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    exp_res = deframe_byte(b);
    pending_results.insert(pending_results.size(), exp_res);
    bytes_sent++;
  endtask

  // Every byte yields a result, so an empty queue means the block is idle;
  // the trailing wait covers the two-stage pipe anyway.
  task automatic settle();
    int unsigned waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  // Writes all six registers back to back; valid drops once at the end.
  task automatic apply_config(input logic [7:0] sf, input logic [7:0] ss,
                              input logic [7:0] ef, input logic [7:0] es,
                              input logic [15:0] lim, input logic [15:0] mask);
    bfr_pkg::cfg_req_t wr [6];
    wr[0] = '{index: bfr_pkg::REG_START_FIRST,  value: {8'h00, sf}};
    wr[1] = '{index: bfr_pkg::REG_START_SECOND, value: {8'h00, ss}};
    wr[2] = '{index: bfr_pkg::REG_END_FIRST,    value: {8'h00, ef}};
    wr[3] = '{index: bfr_pkg::REG_END_SECOND,   value: {8'h00, es}};
    wr[4] = '{index: bfr_pkg::REG_MAX_PAYLOAD,  value: lim};
    wr[5] = '{index: bfr_pkg::REG_SUM_MASK,     value: mask};
    foreach (wr[i]) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.data  <= wr[i];
      do @(posedge clk); while (!cfg_ch.ready);
      unique case (wr[i].index)
        bfr_pkg::REG_START_FIRST:  mark_start_first  = wr[i].value[7:0];
        bfr_pkg::REG_START_SECOND: mark_start_second = wr[i].value[7:0];
        bfr_pkg::REG_END_FIRST:    mark_end_first    = wr[i].value[7:0];
        bfr_pkg::REG_END_SECOND:   mark_end_second   = wr[i].value[7:0];
        bfr_pkg::REG_MAX_PAYLOAD:  payload_limit     = wr[i].value;
        bfr_pkg::REG_SUM_MASK:     sum_limit_mask    = wr[i].value;
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly short payloads; now and then exactly the limit when that is cheap.
  function automatic int unsigned pick_length();
    if (payload_limit <= 16'd24) return $urandom_range(1, int'(payload_limit));
    if (payload_limit <= 16'd300 && $urandom_range(19) == 0) return int'(payload_limit);
    return $urandom_range(1, 24);
  endfunction

  function automatic logic [15:0] pick_bad_length();
    if (payload_limit == 16'hFFFF || $urandom_range(3) == 0) return 16'h0000;
    if ($urandom_range(1) == 1) return payload_limit + 16'd1;
    return 16'($urandom_range(int'(payload_limit) + 1, 65535));
  endfunction

  task automatic send_header(input logic [15:0] len);
    send_byte(mark_start_first);
    send_byte(mark_start_second);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
  endtask

  // Full frame with random payload. sum_fault flips one checksum bit;
  // end_fault 1 or 2 spoils the first or second end byte.
  task automatic send_frame(input int unsigned len, input bit sum_fault,
                            input int unsigned end_fault);
    logic [15:0] total;
    logic [15:0] chk;
    logic [7:0]  b;
    total = '0;
    send_header(16'(len));
    repeat (len) begin
      b     = 8'($urandom_range(255));
      total = total + {8'h00, b};
      send_byte(b);
    end
    chk = total & sum_limit_mask;
    if (sum_fault) chk = chk ^ (16'h0001 << $urandom_range(15));
    send_byte(chk[15:8]);
    send_byte(chk[7:0]);
    if (end_fault == 1) begin
      send_byte(mark_end_first ^ 8'($urandom_range(1, 255)));
    end else begin
      send_byte(mark_end_first);
      send_byte(end_fault == 2 ? mark_end_second ^ 8'($urandom_range(1, 255))
                               : mark_end_second);
    end
  endtask

  // Random traffic: mostly well-formed frames, the rest noise, bad lengths
  // and frames cut short by the next start pair.
  task automatic send_frames(input int unsigned budget);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
      end else if (pick < 18) begin
        send_header(pick_bad_length());
      end else if (pick < 25) begin
        len = pick_length();
        send_header(16'(len));
        repeat ($urandom_range(0, len - 1)) send_byte(8'($urandom_range(255)));
      end else begin
        send_frame(pick_length(), $urandom_range(7) == 0,
                   ($urandom_range(9) == 0) ? $urandom_range(1, 2) : 0);
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  // Reset register values; hand-built stream through every frame event but EV_GOOD.
  task automatic test_directed_frames();
    logic [7:0] seq [30];
    seq = '{8'h00,                                       // hunting, nothing
            8'hA0, 8'hA2, 8'h00, 8'h00,                  // zero length
            8'hA0, 8'hA2, 8'h00, 8'h02, 8'hA0, 8'hA2,    // resync inside payload
            8'h00, 8'h01, 8'hFF, 8'h00, 8'hFE,           // 1-byte payload 0xFF,
            8'hB0, 8'hB3,                                //   checksum off by one
            8'hA0, 8'hA2, 8'h00, 8'h79,                  // length one over limit
            8'hA0, 8'hA2, 8'h00, 8'h01, 8'h55, 8'h00,    // good payload and sum,
            8'h55, 8'hB1};                               //   wrong first end byte
    foreach (seq[i]) send_byte(seq[i]);
    send_frame(pick_length(), 1'b0, 2);                  // wrong second end byte
    settle();
  endtask

  task automatic test_random_defaults();
    send_frames(280);
    settle();
  endtask

  // Marks at the byte extremes, single-byte limit, checksum masked to zero.
  task automatic test_extreme_registers();
    apply_config(8'h00, 8'hFF, 8'hFF, 8'h00, 16'd1, 16'h0000);
    send_frames(220);
    settle();
  endtask

  // Widest limit, low-byte mask, one long payload, no idling on either side.
  task automatic test_wide_frames();
    idle_enabled = 1'b0;
    apply_config(8'h55, 8'hAA, 8'h01, 8'hFE, 16'hFFFF, 16'h00FF);
    send_frame(600, 1'b0, 0);
    send_frames(120);
    settle();
    idle_enabled = 1'b1;
  endtask

  // Output stalled long enough that the block fills and stalls its input.
  task automatic test_output_backpressure();
    apply_config(bfr_pkg::RST_START_FIRST, bfr_pkg::RST_START_SECOND,
                 bfr_pkg::RST_END_FIRST, bfr_pkg::RST_END_SECOND,
                 bfr_pkg::RST_MAX_PAYLOAD, bfr_pkg::RST_SUM_MASK);
    hold_off_req = 1'b1;
    send_frames(250);
    settle();
  endtask

  task automatic test_random_registers();
    repeat (3) begin
      apply_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)),
                   16'($urandom_range(1, 64)), 16'($urandom_range(65535)));
      send_frames(120);
      settle();
    end
  endtask

  // ------------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------------
  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    idle_enabled = 1'b1;
    hold_off_req = 1'b0;
    bytes_sent   = 0;
    mismatches   = 0;
    reset_deframer();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_frames();
    test_random_defaults();
    test_extreme_registers();
    test_wide_frames();
    test_output_backpressure();
    test_random_registers();

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("binary_frame_receiver_top regression: pass");
    end else begin
      $display("binary_frame_receiver_top regression: fail");
    end
    $finish;
  end

endmodule

### binary_frame_receiver_top.f
rtl/core/bfr_pkg.sv
rtl/core/bfr_stream_if.sv
rtl/core/binary_frame_receiver_top.sv
dv/tb_binary_frame_receiver_top.sv
